/* design/line_rasterizer_top_assert.svh */
// ----------------------------------------------------------------------------
// line_rasterizer_top_assert.svh
// assertion macros for the line rasterizer, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_TOP_ASSERT_SVH
`define LINE_RASTERIZER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line rasterizer check failed");

// next-cycle implication
`define LR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line rasterizer check failed");

`else

`define LR_ASSERT_NOW(label, clk, rst, ante, cons)
`define LR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* design/lr_pkg.sv */
// ----------------------------------------------------------------------------
// lr_pkg
// shared constants and control types of the line rasterizer
// ----------------------------------------------------------------------------
package lr_pkg;

   // default coordinate width
   localparam int COORD_BITS_DEF = 12;

   // operation codes
   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // minor axis direction codes
   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_POS  = 2'd1;
   localparam logic [1:0] DIR_NEG  = 2'd3;

   // stage control from the input register to the engine
   typedef struct packed {
      logic advance;
      logic start;
      logic step;
   } lr_ctl_type;

   // engine status back to the input register
   typedef struct packed {
      logic out_free;
   } lr_stat_type;

endpackage

/* design/lr_if.sv */
// ----------------------------------------------------------------------------
// lr_req_if / lr_rsp_if
// valid/ready channels for line requests and pixel results
// ----------------------------------------------------------------------------
interface lr_req_if #(parameter int COORD_BITS = 12);
   logic                  valid;
   logic                  ready;
   logic                  op;
   logic [COORD_BITS-1:0] start_x;
   logic [COORD_BITS-1:0] start_y;
   logic [COORD_BITS-1:0] end_x;
   logic [COORD_BITS-1:0] end_y;

   modport source (output valid, op, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, op, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lr_rsp_if #(parameter int COORD_BITS = 12);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;
   logic                  last;

   modport source (output valid, pixel_x, pixel_y, last, input ready);
   modport sink   (input valid, pixel_x, pixel_y, last, output ready);
endinterface

/* design/lr_setup.sv */
// ----------------------------------------------------------------------------
// lr_setup
// line setup: major axis, endpoint order, error term and increments
// ----------------------------------------------------------------------------
module lr_setup
   import lr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int ERR_BITS  = COORD_BITS + 3
) (
   input  logic [COORD_BITS-1:0]      start_x,
   input  logic [COORD_BITS-1:0]      start_y,
   input  logic [COORD_BITS-1:0]      end_x,
   input  logic [COORD_BITS-1:0]      end_y,
   output logic                       x_major,
   output logic [COORD_BITS-1:0]      first_x,
   output logic [COORD_BITS-1:0]      first_y,
   output logic [COORD_BITS-1:0]      stop_major,
   output logic signed [ERR_BITS-1:0] err_init,
   output logic signed [ERR_BITS-1:0] inc_straight,
   output logic signed [ERR_BITS-1:0] inc_diagonal,
   output logic [1:0]                 minor_dir,
   output logic                       single
);

   logic [COORD_BITS-1:0]      adx, ady, major_len, minor_len;
   logic [COORD_BITS-1:0]      last_x, last_y, minor_first, minor_last;
   logic                       swap;
   logic signed [ERR_BITS-1:0] major_e, minor_e;

   // absolute deltas and axis choice, a tie goes to x
   assign adx     = (end_x >= start_x) ? end_x - start_x : start_x - end_x;
   assign ady     = (end_y >= start_y) ? end_y - start_y : start_y - end_y;
   assign x_major = adx >= ady;

   // order the endpoints along the major axis
   assign swap    = x_major ? (start_x > end_x) : (start_y > end_y);
   assign first_x = swap ? end_x : start_x;
   assign first_y = swap ? end_y : start_y;
   assign last_x  = swap ? start_x : end_x;
   assign last_y  = swap ? start_y : end_y;

   assign major_len  = x_major ? adx : ady;
   assign minor_len  = x_major ? ady : adx;
   assign stop_major = x_major ? last_x : last_y;
   assign single     = major_len == '0;

   // minor direction from the ordered endpoints
   assign minor_first = x_major ? first_y : first_x;
   assign minor_last  = x_major ? last_y : last_x;
   always_comb begin
      priority if (minor_last > minor_first) begin
         minor_dir = DIR_POS;
      end else if (minor_last < minor_first) begin
         minor_dir = DIR_NEG;
      end else begin
         minor_dir = DIR_NONE;
      end
   end

   // decision variable and its two increments
   assign major_e      = signed'({3'b000, major_len});
   assign minor_e      = signed'({3'b000, minor_len});
   assign err_init     = (minor_e <<< 1) - major_e;
   assign inc_straight = minor_e <<< 1;
   assign inc_diagonal = (minor_e - major_e) <<< 1;

endmodule

/* design/lr_engine.sv */
// ----------------------------------------------------------------------------
// lr_engine
// line state, one pixel step per item, and the result register
// ----------------------------------------------------------------------------
`include "line_rasterizer_top_assert.svh"

module lr_engine
   import lr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int ERR_BITS  = COORD_BITS + 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lr_ctl_type            ctl,
   output lr_stat_type           stat,
   input  logic [COORD_BITS-1:0] start_x,
   input  logic [COORD_BITS-1:0] start_y,
   input  logic [COORD_BITS-1:0] end_x,
   input  logic [COORD_BITS-1:0] end_y,
   lr_rsp_if.source              rsp
);

   // line state
   logic [COORD_BITS-1:0]      cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0]      stop_major_ff, stop_major_in;
   logic signed [ERR_BITS-1:0] err_ff, err_in, inc_s_ff, inc_s_in, inc_d_ff, inc_d_in;
   logic [1:0]                 minor_dir_ff, minor_dir_in;
   logic                       x_major_ff, x_major_in, busy_ff, busy_in;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic [COORD_BITS-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic                  out_last_ff, out_last_in;

   // setup results
   logic                       su_x_major, su_single;
   logic [COORD_BITS-1:0]      su_first_x, su_first_y, su_stop;
   logic signed [ERR_BITS-1:0] su_err, su_inc_s, su_inc_d;
   logic [1:0]                 su_dir;

   // step datapath
   logic [COORD_BITS-1:0] maj_cur, mnr_cur, maj_next, mnr_next;
   logic                  diag, fin, produce;

   lr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
      .start_x      (start_x),
      .start_y      (start_y),
      .end_x        (end_x),
      .end_y        (end_y),
      .x_major      (su_x_major),
      .first_x      (su_first_x),
      .first_y      (su_first_y),
      .stop_major   (su_stop),
      .err_init     (su_err),
      .inc_straight (su_inc_s),
      .inc_diagonal (su_inc_d),
      .minor_dir    (su_dir),
      .single       (su_single)
   );

   // result register can take a new pixel
   assign stat.out_free = !out_valid_ff || rsp.ready;

   // one step along the line
   assign maj_cur  = x_major_ff ? cur_x_ff : cur_y_ff;
   assign mnr_cur  = x_major_ff ? cur_y_ff : cur_x_ff;
   assign diag     = !err_ff[ERR_BITS-1];
   assign maj_next = maj_cur + COORD_BITS'(1);
   always_comb begin
      mnr_next = mnr_cur;
      if (diag && minor_dir_ff == DIR_POS) begin
         mnr_next = mnr_cur + COORD_BITS'(1);
      end else if (diag && minor_dir_ff == DIR_NEG) begin
         mnr_next = mnr_cur - COORD_BITS'(1);
      end
   end
   assign fin = maj_next == stop_major_ff;

   assign produce = ctl.advance && (ctl.start || (ctl.step && busy_ff));

   // next state
   always_comb begin
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      stop_major_in = stop_major_ff;
      err_in        = err_ff;
      inc_s_in      = inc_s_ff;
      inc_d_in      = inc_d_ff;
      minor_dir_in  = minor_dir_ff;
      x_major_in    = x_major_ff;
      busy_in       = busy_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_last_in   = out_last_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      if (ctl.advance && ctl.start) begin
         cur_x_in      = su_first_x;
         cur_y_in      = su_first_y;
         stop_major_in = su_stop;
         err_in        = su_err;
         inc_s_in      = su_inc_s;
         inc_d_in      = su_inc_d;
         minor_dir_in  = su_dir;
         x_major_in    = su_x_major;
         busy_in       = !su_single;
         out_x_in      = su_first_x;
         out_y_in      = su_first_y;
         out_last_in   = su_single;
         out_valid_in  = 1'b1;
      end else if (produce) begin
         cur_x_in     = x_major_ff ? maj_next : mnr_next;
         cur_y_in     = x_major_ff ? mnr_next : maj_next;
         err_in       = err_ff + (diag ? inc_d_ff : inc_s_ff);
         busy_in      = !fin;
         out_x_in     = cur_x_in;
         out_y_in     = cur_y_in;
         out_last_in  = fin;
         out_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         stop_major_ff <= '0;
         err_ff        <= '0;
         inc_s_ff      <= '0;
         inc_d_ff      <= '0;
         minor_dir_ff  <= DIR_NONE;
         x_major_ff    <= 1'b0;
         busy_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         stop_major_ff <= stop_major_in;
         err_ff        <= err_in;
         inc_s_ff      <= inc_s_in;
         inc_d_ff      <= inc_d_in;
         minor_dir_ff  <= minor_dir_in;
         x_major_ff    <= x_major_in;
         busy_ff       <= busy_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_last_ff <= out_last_in;
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.pixel_x = out_x_ff;
   assign rsp.pixel_y = out_y_ff;
   assign rsp.last    = out_last_ff;

   // checks
   `LR_ASSERT_NEXT(a_idle_step_silent, clock, reset, ctl.advance && ctl.step && !busy_ff, !out_valid_ff)
   `LR_ASSERT_NEXT(a_start_emits, clock, reset, ctl.advance && ctl.start, out_valid_ff && busy_ff == !out_last_ff)
   `LR_ASSERT_NEXT(a_last_ends_line, clock, reset, produce && out_last_in, !busy_ff)
   `LR_ASSERT_NOW(a_advance_needs_room, clock, reset, ctl.advance, stat.out_free)

endmodule

/* design/line_rasterizer_top.sv */
// ----------------------------------------------------------------------------
// line_rasterizer_top
// Bresenham line generator, at most one pixel per transfer
// ----------------------------------------------------------------------------
// A start transfer (op = 0) sets up a line between two endpoints and returns
// its first pixel; each step transfer (op = 1) returns the next pixel, and the
// far endpoint comes back once with last set. A step while no line is active
// returns nothing, and a start abandons any running line. The block takes one
// transfer per clock and returns one pixel per clock while the result side is
// ready: a request passes an input register, then the combinational setup or
// step logic, and lands in the result register together with the line state
// update.
module line_rasterizer_top
   import lr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input logic      clock,
   input logic      reset,
   lr_req_if.sink   req_chan,
   lr_rsp_if.source rsp_chan
);

   logic                  in_valid_ff, in_valid_in;
   logic                  in_op_ff;
   logic [COORD_BITS-1:0] in_sx_ff, in_sy_ff, in_ex_ff, in_ey_ff;
   lr_ctl_type            ctl;
   lr_stat_type           stat;

   // held request moves on when the result register has room
   assign ctl.advance = in_valid_ff && stat.out_free;
   assign ctl.start   = in_op_ff == OP_START;
   assign ctl.step    = in_op_ff == OP_STEP;

   assign req_chan.ready = !in_valid_ff || ctl.advance;
   assign in_valid_in    = req_chan.valid || (in_valid_ff && !ctl.advance);

   // input register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= in_valid_in;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_op_ff <= req_chan.op;
         in_sx_ff <= req_chan.start_x;
         in_sy_ff <= req_chan.start_y;
         in_ex_ff <= req_chan.end_x;
         in_ey_ff <= req_chan.end_y;
      end
   end

   lr_engine #(.COORD_BITS(COORD_BITS)) u_engine (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .stat    (stat),
      .start_x (in_sx_ff),
      .start_y (in_sy_ff),
      .end_x   (in_ex_ff),
      .end_y   (in_ey_ff),
      .rsp     (rsp_chan)
   );

endmodule
